// ===== rtl/costmap_obstacle_inflation_macros.svh =====
// Assertion macros for the costmap obstacle inflation block.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef COSTMAP_OBSTACLE_INFLATION_MACROS_SVH
`define COSTMAP_OBSTACLE_INFLATION_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define COI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define COI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/coi_pkg.sv =====
// Shared types and constants of the costmap obstacle inflation block.
// No dependencies; used by every module of the block.
`default_nettype none

package coi_pkg;

    localparam int unsigned TABLE_DEPTH = 4097;
    localparam int unsigned TBL_AW      = 13;
    localparam int unsigned DIST_W      = 14;
    localparam int unsigned COST_W      = 8;
    localparam int unsigned SQ_W        = 13;

    localparam logic [TBL_AW-1:0] TABLE_LAST    = 13'd4096;
    localparam logic [DIST_W-1:0] DIST_MAX      = 14'h3FFF;
    localparam logic [COST_W-1:0] COST_UNKNOWN  = 8'd255;
    localparam logic [COST_W-1:0] COST_CENTER   = 8'd254;
    localparam logic [COST_W-1:0] COST_INSCRIBED = 8'd253;
    localparam logic [COST_W-1:0] COST_FREE     = 8'd0;

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_MARK    = 3'd1,
        OP_INFLATE = 3'd2,
        OP_READ    = 3'd3,
        OP_LOAD    = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_WINDOW_HALF  = 3'd0,
        CFG_INFLATION_SQ = 3'd1,
        CFG_INSCRIBED_SQ = 3'd2,
        CFG_GRID_WIDTH   = 3'd3,
        CFG_GRID_HEIGHT  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_INFL,
        ST_DRAIN,
        ST_RDWAIT,
        ST_RESP
    } t_state;

    // Sequencer requests to the cell store
    typedef struct packed {
        logic rd_en;
        logic dc_we;
        logic lt_we;
        logic lt_val;
    } t_store_ctl;

endpackage

`default_nettype wire

// ===== rtl/coi_cell_store.sv =====
// Cell store: lethal flags and distance/cost words, one entry per grid cell.
// Depends on coi_pkg.
`default_nettype none

module coi_cell_store #(
    parameter int CELL_COUNT = 131072,
    parameter int ADDR_W     = 17
) (
    input  wire                        i_clk,
    input  coi_pkg::t_store_ctl        i_ctl,
    input  wire  [ADDR_W-1:0]          i_rd_addr,
    input  wire  [ADDR_W-1:0]          i_lt_addr,
    input  wire  [ADDR_W-1:0]          i_dc_addr,
    input  wire  [coi_pkg::DIST_W-1:0] i_dc_dist,
    input  wire  [coi_pkg::COST_W-1:0] i_dc_cost,
    output logic                       o_lethal,
    output logic [coi_pkg::DIST_W-1:0] o_dist,
    output logic [coi_pkg::COST_W-1:0] o_cost
);
    import coi_pkg::*;

    localparam int DC_W = DIST_W + COST_W;

    logic            r_lethal_mem [0:CELL_COUNT-1];
    logic [DC_W-1:0] r_dc_mem     [0:CELL_COUNT-1];
    logic [DC_W-1:0] r_dc_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.lt_we) begin
            r_lethal_mem[i_lt_addr] <= i_ctl.lt_val;
        end
        if (i_ctl.rd_en) begin
            o_lethal <= r_lethal_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.dc_we) begin
            r_dc_mem[i_dc_addr] <= {i_dc_dist, i_dc_cost};
        end
        if (i_ctl.rd_en) begin
            r_dc_q <= r_dc_mem[i_rd_addr];
        end
    end

    assign o_dist = r_dc_q[DC_W-1:COST_W];
    assign o_cost = r_dc_q[COST_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/coi_cell_eval.sv =====
// Cell evaluator: squared distance, band-cost table, compare and update.
// Depends on coi_pkg; reads the cell store in the cycle after each issue.
`default_nettype none

module coi_cell_eval #(
    parameter int ADDR_W = 17
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_iss_valid,
    input  wire  signed [6:0]          i_dx,
    input  wire  signed [6:0]          i_dy,
    input  wire  [ADDR_W-1:0]          i_addr,
    input  wire                        i_tbl_we,
    input  wire  [coi_pkg::TBL_AW-1:0] i_tbl_idx,
    input  wire  [coi_pkg::COST_W-1:0] i_tbl_val,
    input  wire  [12:0]                i_infl_sq,
    input  wire  [12:0]                i_inscr_sq,
    input  wire                        i_lethal,
    input  wire  [coi_pkg::DIST_W-1:0] i_dist,
    output logic                       o_we,
    output logic [ADDR_W-1:0]          o_addr,
    output logic [coi_pkg::DIST_W-1:0] o_dist,
    output logic [coi_pkg::COST_W-1:0] o_cost
);
    import coi_pkg::*;

    logic [COST_W-1:0] r_tbl [0:TABLE_DEPTH-1];
    logic [COST_W-1:0] r_tbl_q;

    logic [6:0]        w_dxu;
    logic [6:0]        w_dyu;
    logic [5:0]        w_adx;
    logic [5:0]        w_ady;
    logic [11:0]       w_sqx;
    logic [11:0]       w_sqy;
    logic [SQ_W-1:0]   w_s;

    logic              r_p_valid;
    logic [SQ_W-1:0]   r_p_s;
    logic [ADDR_W-1:0] r_p_addr;
    logic              w_band;

    always_comb begin
        w_dxu = i_dx;
        w_dyu = i_dy;
        w_adx = w_dxu[6] ? 6'(~w_dxu + 7'd1) : w_dxu[5:0];
        w_ady = w_dyu[6] ? 6'(~w_dyu + 7'd1) : w_dyu[5:0];
        w_sqx = 12'(w_adx) * 12'(w_adx);
        w_sqy = 12'(w_ady) * 12'(w_ady);
        w_s   = 13'(w_sqx) + 13'(w_sqy);
    end

    // table write from load, table read for the cell being issued
    always_ff @(posedge i_clk) begin
        if (i_tbl_we) begin
            r_tbl[i_tbl_idx] <= i_tbl_val;
        end
        if (i_iss_valid && (w_s <= TABLE_LAST)) begin
            r_tbl_q <= r_tbl[w_s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_iss_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_iss_valid) begin
            r_p_s    <= w_s;
            r_p_addr <= i_addr;
        end
    end

    always_comb begin
        w_band = (i_inscr_sq <= r_p_s) && (r_p_s <= i_infl_sq) && (r_p_s <= TABLE_LAST);
        priority if (w_band) begin
            o_cost = r_tbl_q;
        end else if ((r_p_s != '0) && (r_p_s < i_inscr_sq)) begin
            o_cost = COST_INSCRIBED;
        end else if (r_p_s == '0) begin
            o_cost = COST_CENTER;
        end else begin
            o_cost = COST_FREE;
        end
        o_we   = r_p_valid && !i_lethal && (DIST_W'(r_p_s) < i_dist);
        o_addr = r_p_addr;
        o_dist = DIST_W'(r_p_s);
    end

endmodule

`default_nettype wire

// ===== rtl/coi_seq.sv =====
// Sequencer: item decode, clearing sweeps, window walk and result hand-off.
// Depends on coi_pkg; drives coi_cell_store and coi_cell_eval.
`default_nettype none

module coi_seq #(
    parameter int GRID_COLS       = 512,
    parameter int GRID_ROWS       = 256,
    parameter int MAX_WINDOW_HALF = 63,
    parameter int ADDR_W          = 17
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [2:0]                 i_op,
    input  wire  [8:0]                 i_x,
    input  wire  [7:0]                 i_y,
    input  wire  [coi_pkg::TBL_AW-1:0] i_tidx,
    input  wire  [coi_pkg::COST_W-1:0] i_tval,
    input  wire  [5:0]                 i_half,
    input  wire  [9:0]                 i_cols,
    input  wire  [8:0]                 i_rows,
    input  wire                        i_slot_free,
    input  wire  [coi_pkg::COST_W-1:0] i_rd_cost,
    output logic                       o_ready,
    output coi_pkg::t_store_ctl        o_ctl,
    output logic [ADDR_W-1:0]          o_rd_addr,
    output logic [ADDR_W-1:0]          o_wr_addr,
    output logic                       o_iss_valid,
    output logic signed [6:0]          o_dx,
    output logic signed [6:0]          o_dy,
    output logic                       o_tbl_we,
    output logic [coi_pkg::TBL_AW-1:0] o_tbl_idx,
    output logic [coi_pkg::COST_W-1:0] o_tbl_val,
    output logic                       o_done,
    output logic [coi_pkg::COST_W-1:0] o_cost,
    output logic                       o_status
);
    import coi_pkg::*;

    localparam int                CELL_COUNT = GRID_COLS * GRID_ROWS;
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [12:0]       COLS_C     = 13'(GRID_COLS);
    localparam logic [12:0]       ROWS_C     = 13'(GRID_ROWS);
    localparam logic [8:0]        MAXH_C     = 9'(MAX_WINDOW_HALF);

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic signed [6:0] r_dx, n_dx;
    logic signed [6:0] r_dy, n_dy;
    logic [COST_W-1:0] r_cost, n_cost;
    logic              r_status, n_status;

    t_opcode           r_op;
    logic [8:0]        r_x;
    logic [7:0]        r_y;
    logic [TBL_AW-1:0] r_tidx;
    logic [COST_W-1:0] r_tval;

    logic [5:0]        w_half;
    logic signed [6:0] w_h;
    logic              w_inside;
    logic [ADDR_W-1:0] w_item_addr;
    logic signed [10:0] w_wx;
    logic signed [9:0] w_wy;
    logic              w_win_in;
    logic [ADDR_W-1:0] w_win_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_addr   <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_cost   <= '0;
            r_status <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_cost   <= n_cost;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= t_opcode'(i_op);
            r_x    <= i_x;
            r_y    <= i_y;
            r_tidx <= i_tidx;
            r_tval <= i_tval;
        end
    end

    always_comb begin
        w_half = (9'(i_half) > MAXH_C) ? 6'(MAX_WINDOW_HALF) : i_half;
        w_h    = $signed({1'b0, w_half});

        w_inside = ({1'b0, r_x} < i_cols) && (13'(r_x) < COLS_C)
                && ({1'b0, r_y} < i_rows) && (13'(r_y) < ROWS_C);
        w_item_addr = ADDR_W'(ADDR_W'(r_y) * ADDR_W'(GRID_COLS)) + ADDR_W'(r_x);

        // window cell, signed so that cells left of or above the grid show up
        w_wx = $signed({2'b00, r_x}) + 11'(r_dx);
        w_wy = $signed({2'b00, r_y}) + 10'(r_dy);
        w_win_in = !w_wx[10] && (w_wx[9:0] < i_cols) && (13'(w_wx[9:0]) < COLS_C)
                && !w_wy[9] && (w_wy[8:0] < i_rows) && (13'(w_wy[8:0]) < ROWS_C);
        w_win_addr = ADDR_W'(ADDR_W'(w_wy[8:0]) * ADDR_W'(GRID_COLS))
                   + ADDR_W'(w_wx[9:0]);
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_cost      = r_cost;
        n_status    = r_status;
        o_ctl       = '0;
        o_rd_addr   = w_item_addr;
        o_wr_addr   = r_addr;
        o_iss_valid = 1'b0;
        o_tbl_we    = 1'b0;
        o_done      = 1'b0;

        unique case (r_state)
            ST_INIT: begin
                o_ctl.dc_we  = 1'b1;
                o_ctl.lt_we  = 1'b1;
                o_ctl.lt_val = 1'b0;
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_cost   = '0;
                n_status = 1'b0;
                n_state  = ST_RESP;
                case (r_op)
                    OP_CLEAR: begin
                        n_addr  = '0;
                        n_state = ST_CLEAR;
                    end
                    OP_MARK: begin
                        if (w_inside) begin
                            o_ctl.lt_we  = 1'b1;
                            o_ctl.lt_val = 1'b1;
                            o_wr_addr    = w_item_addr;
                        end else begin
                            n_status = 1'b1;
                        end
                    end
                    OP_INFLATE: begin
                        if (w_inside) begin
                            n_dx    = -w_h;
                            n_dy    = -w_h;
                            n_state = ST_INFL;
                        end else begin
                            n_status = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (w_inside) begin
                            o_ctl.rd_en = 1'b1;
                            n_state     = ST_RDWAIT;
                        end else begin
                            n_status = 1'b1;
                        end
                    end
                    OP_LOAD: begin
                        if (r_tidx <= TABLE_LAST) begin
                            o_tbl_we = 1'b1;
                        end else begin
                            n_status = 1'b1;
                        end
                    end
                    default: begin
                        n_status = 1'b0;
                    end
                endcase
            end
            ST_CLEAR: begin
                o_ctl.dc_we = 1'b1;
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = ST_RESP;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            ST_INFL: begin
                // column-major walk, one window cell per cycle
                o_iss_valid = w_win_in;
                o_ctl.rd_en = w_win_in;
                o_rd_addr   = w_win_addr;
                if (r_dy == w_h) begin
                    n_dy = -w_h;
                    if (r_dx == w_h) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_dx = r_dx + 7'sd1;
                    end
                end else begin
                    n_dy = r_dy + 7'sd1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_RESP;
            end
            ST_RDWAIT: begin
                n_cost  = i_rd_cost;
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_slot_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready   = (r_state == ST_IDLE);
    assign o_dx      = r_dx;
    assign o_dy      = r_dy;
    assign o_tbl_idx = r_tidx;
    assign o_tbl_val = r_tval;
    assign o_cost    = r_cost;
    assign o_status  = r_status;

endmodule

`default_nettype wire

// ===== rtl/costmap_obstacle_inflation.sv =====
// Costmap obstacle inflation engine, top level: ports, registers, result stage.
// Depends on coi_pkg, coi_seq, coi_cell_eval, coi_cell_store and the macros header.
//
// Keeps a GRID_COLS x GRID_ROWS grid of cells (cost byte, squared distance,
// lethal flag) and handles one command per input transfer, returning exactly one
// result transfer per command. Commands are taken one at a time: s_tready is
// high only while the sequencer is idle, and a finished result may still wait in
// the output register while the next command is taken. Each command ends in the
// result state, which raises m_tvalid as s_tready comes back on the same edge:
// mark, load table and unused opcodes go there from decode; read cost first waits
// for the store read; inflate first walks the (2h+1)^2 window, where h is the
// window half size clamped to MAX_WINDOW_HALF (25 at reset), and drains it; clear
// first sweeps the whole store. A command waits in the result state while a
// previous result still sits in the output register unaccepted.
// Inflate and clear take one cell per cycle, whether or not the window cell lies
// in the grid. After reset the block sweeps the whole store once (131072 cells at
// default size) before it takes its first command; config writes are taken during
// the sweep. The band-cost table holds garbage until loaded, so load every entry
// used by the inscribed..inflation band before inflating.
`default_nettype none

module costmap_obstacle_inflation #(
    parameter int GRID_COLS       = 512,
    parameter int GRID_ROWS       = 256,
    parameter int MAX_WINDOW_HALF = 63
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // command stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // opcode[2:0], cell_x[11:3], cell_y[19:12],
                                   // table_index[32:20], table_value[40:33], zero fill
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // cell_cost[7:0], status[8], zero fill
    // register writes
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [12:0] i_cfg_data
);
    import coi_pkg::*;

    `include "costmap_obstacle_inflation_macros.svh"

    localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // config registers
    logic [5:0]  r_window_half;
    logic [12:0] r_infl_sq;
    logic [12:0] r_inscr_sq;
    logic [9:0]  r_grid_width;
    logic [8:0]  r_grid_height;

    // result stage
    logic              r_m_valid;
    logic [COST_W-1:0] r_m_cost;
    logic              r_m_status;

    logic              w_accept;
    logic              w_slot_free;

    t_store_ctl        w_seq_ctl;
    t_store_ctl        w_store_ctl;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [ADDR_W-1:0] w_wr_addr;
    logic              w_iss_valid;
    logic signed [6:0] w_dx;
    logic signed [6:0] w_dy;
    logic              w_tbl_we;
    logic [TBL_AW-1:0] w_tbl_idx;
    logic [COST_W-1:0] w_tbl_val;
    logic              w_done;
    logic [COST_W-1:0] w_res_cost;
    logic              w_res_status;

    logic              w_lethal;
    logic [DIST_W-1:0] w_dist;
    logic [COST_W-1:0] w_cost_rd;

    logic              w_ev_we;
    logic [ADDR_W-1:0] w_ev_addr;
    logic [DIST_W-1:0] w_ev_dist;
    logic [COST_W-1:0] w_ev_cost;

    logic [ADDR_W-1:0] w_dc_addr;
    logic [DIST_W-1:0] w_dc_dist;
    logic [COST_W-1:0] w_dc_cost;

    assign w_accept    = s_tvalid && s_tready;
    assign w_slot_free = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_half <= 6'd25;
            r_infl_sq     <= 13'd625;
            r_inscr_sq    <= 13'd225;
            r_grid_width  <= 10'd512;
            r_grid_height <= 9'd256;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW_HALF:  r_window_half <= i_cfg_data[5:0];
                CFG_INFLATION_SQ: r_infl_sq     <= i_cfg_data;
                CFG_INSCRIBED_SQ: r_inscr_sq    <= i_cfg_data;
                CFG_GRID_WIDTH:   r_grid_width  <= i_cfg_data[9:0];
                CFG_GRID_HEIGHT:  r_grid_height <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    coi_seq #(
        .GRID_COLS       (GRID_COLS),
        .GRID_ROWS       (GRID_ROWS),
        .MAX_WINDOW_HALF (MAX_WINDOW_HALF),
        .ADDR_W          (ADDR_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_op        (s_tdata[2:0]),
        .i_x         (s_tdata[11:3]),
        .i_y         (s_tdata[19:12]),
        .i_tidx      (s_tdata[32:20]),
        .i_tval      (s_tdata[40:33]),
        .i_half      (r_window_half),
        .i_cols      (r_grid_width),
        .i_rows      (r_grid_height),
        .i_slot_free (w_slot_free),
        .i_rd_cost   (w_cost_rd),
        .o_ready     (s_tready),
        .o_ctl       (w_seq_ctl),
        .o_rd_addr   (w_rd_addr),
        .o_wr_addr   (w_wr_addr),
        .o_iss_valid (w_iss_valid),
        .o_dx        (w_dx),
        .o_dy        (w_dy),
        .o_tbl_we    (w_tbl_we),
        .o_tbl_idx   (w_tbl_idx),
        .o_tbl_val   (w_tbl_val),
        .o_done      (w_done),
        .o_cost      (w_res_cost),
        .o_status    (w_res_status)
    );

    coi_cell_eval #(
        .ADDR_W (ADDR_W)
    ) u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_iss_valid (w_iss_valid),
        .i_dx        (w_dx),
        .i_dy        (w_dy),
        .i_addr      (w_rd_addr),
        .i_tbl_we    (w_tbl_we),
        .i_tbl_idx   (w_tbl_idx),
        .i_tbl_val   (w_tbl_val),
        .i_infl_sq   (r_infl_sq),
        .i_inscr_sq  (r_inscr_sq),
        .i_lethal    (w_lethal),
        .i_dist      (w_dist),
        .o_we        (w_ev_we),
        .o_addr      (w_ev_addr),
        .o_dist      (w_ev_dist),
        .o_cost      (w_ev_cost)
    );

    // distance/cost write: sweep writes from the sequencer, updates from the evaluator
    always_comb begin
        w_store_ctl       = w_seq_ctl;
        w_store_ctl.dc_we = w_seq_ctl.dc_we || w_ev_we;
        if (w_seq_ctl.dc_we) begin
            w_dc_addr = w_wr_addr;
            w_dc_dist = DIST_MAX;
            w_dc_cost = COST_UNKNOWN;
        end else begin
            w_dc_addr = w_ev_addr;
            w_dc_dist = w_ev_dist;
            w_dc_cost = w_ev_cost;
        end
    end

    coi_cell_store #(
        .CELL_COUNT (CELL_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (w_store_ctl),
        .i_rd_addr (w_rd_addr),
        .i_lt_addr (w_wr_addr),
        .i_dc_addr (w_dc_addr),
        .i_dc_dist (w_dc_dist),
        .i_dc_cost (w_dc_cost),
        .o_lethal  (w_lethal),
        .o_dist    (w_dist),
        .o_cost    (w_cost_rd)
    );

    // result register: filled when the slot is free, emptied on a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_done) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_m_cost   <= w_res_cost;
            r_m_status <= w_res_status;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {7'd0, r_m_status, r_m_cost};

    // one command in flight at a time
    `COI_ASSERT_NXT(a_busy_after_accept, w_accept, !s_tready, "ready right after a command transfer")
    // sweep and cell updates never share the store write port
    `COI_ASSERT_IMP(a_single_writer, w_seq_ctl.dc_we, !w_ev_we, "sweep write collides with update")
    // a result is only loaded into a free output slot
    `COI_ASSERT_IMP(a_done_slot_free, w_done, w_slot_free, "result overwrites a pending result")
    // cell updates happen only while a command is being worked on
    `COI_ASSERT_IMP(a_update_while_busy, w_ev_we, !s_tready, "cell update while idle")

endmodule

`default_nettype wire
